@@ hdl/pdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Place distance matrix package
// Shared sizes, command codes and memory geometry.
// ----------------------------------------------------------------------------
package pdm_pkg;

    localparam int MaxPlaces      = 64;
    localparam int MaxTransitions = 64;
    localparam int InfDist        = 255;

    localparam int PlaceW = $clog2(MaxPlaces);
    localparam int TransW = $clog2(MaxTransitions);
    localparam int CountW = PlaceW + 1;
    localparam int AddrW  = 2 * PlaceW;
    localparam int DistW  = 8;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    localparam logic [DistW-1:0] INF_CODE = DistW'(InfDist);

    typedef logic [MaxPlaces-1:0] flag_row_t;

endpackage

@@ hdl/pdm_dist_ram.sv @@
// ----------------------------------------------------------------------------
// Distance matrix memory
// One write port and one registered read port over all matrix entries.
// ----------------------------------------------------------------------------
module pdm_dist_ram
    import pdm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AddrW-1:0]     waddr,
    input  logic [DistW-1:0]     wdata,
    input  logic [AddrW-1:0]     raddr,
    output logic [DistW-1:0]     rdata
);

    logic [DistW-1:0] mem [MaxPlaces*MaxPlaces];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/pdm_order_ram.sv @@
// ----------------------------------------------------------------------------
// Order list memory
// One write port and one registered read port over all order entries.
// ----------------------------------------------------------------------------
module pdm_order_ram
    import pdm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AddrW-1:0]     waddr,
    input  logic [PlaceW-1:0]    wdata,
    input  logic [AddrW-1:0]     raddr,
    output logic [PlaceW-1:0]    rdata
);

    logic [PlaceW-1:0] mem [MaxPlaces*MaxPlaces];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/place_distance_matrix_with_order.sv @@
// ----------------------------------------------------------------------------
// Place distance matrix with order lists
// Loads net arcs, computes all-pairs distances with one shared
// add-compare unit, sorts places by distance per column, answers queries.
// ----------------------------------------------------------------------------
// channel | direction | ports
// s_      | in        | s_valid s_ready s_cmd s_place_a s_place_b ...
// m_      | out       | m_valid m_ready m_distance m_order_place m_done_res
// apb     | config    | psel penable pwrite paddr pwdata prdata pready
//
// Clear passes to the output state, load writes the flag rows first, query reads both memories.
// Compute initialises the n*n matrix entries, seeds them from each of all 64 transitions,
// relaxes n*n*n closure cells, runs n*n*n scan steps plus n*n order writes,
// and finishes through the output state.
// Reset is synchronous; the matrices hold no reset state, flag rows use valid bits.
// A result holds in the output register until taken, and s_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module place_distance_matrix_with_order
    import pdm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [5:0]           s_place_a,
    input  logic [5:0]           s_place_b,
    input  logic [5:0]           s_transition_index,
    input  logic [15:0]          s_weight_in,
    input  logic [15:0]          s_weight_out,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_distance,
    output logic [5:0]           m_order_place,
    output logic                 m_done_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_SEEDT = 4'd2;
    localparam logic [3:0] ST_SEEDW = 4'd3;
    localparam logic [3:0] ST_FWA   = 4'd4;
    localparam logic [3:0] ST_FWB   = 4'd5;
    localparam logic [3:0] ST_FWC   = 4'd6;
    localparam logic [3:0] ST_FWD   = 4'd7;
    localparam logic [3:0] ST_SRD   = 4'd8;
    localparam logic [3:0] ST_SCMP  = 4'd9;
    localparam logic [3:0] ST_SWR   = 4'd10;
    localparam logic [3:0] ST_QRD   = 4'd11;
    localparam logic [3:0] ST_QOUT  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;
    localparam logic [3:0] ST_LWR   = 4'd14;

    logic [3:0]          state_reg, state_next;
    logic [CountW-1:0]   count_reg;
    logic [PlaceW-1:0]   n1;
    logic [CountW-1:0]   n_eff;
    flag_row_t           cons_mem [MaxTransitions];
    flag_row_t           prod_mem [MaxTransitions];
    flag_row_t           crd_reg, prd_reg;
    flag_row_t           crow, prow, cwrow, pwrow;
    logic [MaxTransitions-1:0] tvalid_reg;
    logic [TransW-1:0]   fraddr;
    logic [TransW-1:0]   lt_reg;
    logic [PlaceW-1:0]   lp_reg;
    logic                lc_reg, lpr_reg;
    flag_row_t           taken_reg;
    logic [PlaceW-1:0]   i_reg, j_reg, k_reg;
    logic [TransW-1:0]   t_reg;
    logic [DistW-1:0]    a_reg, b_reg, best_reg;
    logic [PlaceW-1:0]   pick_reg;
    logic [PlaceW-1:0]   qa_reg, qb_reg;
    logic                qin_reg;
    logic [7:0]          odist_reg;
    logic [5:0]          oord_reg;
    logic                ovalid_reg;

    logic                dwe, owe;
    logic [AddrW-1:0]    dwaddr, draddr, owaddr, oraddr;
    logic [DistW-1:0]    dwdata, drdata;
    logic [PlaceW-1:0]   ordata;
    logic [DistW:0]      sum;
    logic [DistW-1:0]    sat;
    logic                last_i, last_j, last_k;
    logic signed [16:0]  wdiff;

    always_comb begin
        priority if (count_reg == '0) begin
            n_eff = CountW'(1);
        end else if (count_reg > CountW'(MaxPlaces)) begin
            n_eff = CountW'(MaxPlaces);
        end else begin
            n_eff = count_reg;
        end
    end
    assign n1     = PlaceW'(n_eff - CountW'(1));
    assign last_i = (i_reg == n1);
    assign last_j = (j_reg == n1);
    assign last_k = (k_reg == n1);
    assign wdiff  = $signed({1'b0, s_weight_in}) - $signed({1'b0, s_weight_out});
    assign sum    = {1'b0, a_reg} + {1'b0, b_reg};
    assign sat    = (a_reg == INF_CODE || b_reg == INF_CODE || sum >= (DistW+1)'(InfDist))
                    ? INF_CODE : sum[DistW-1:0];

    assign fraddr = (state_reg == ST_IDLE) ? s_transition_index : t_reg;
    assign crow   = tvalid_reg[t_reg] ? crd_reg : '0;
    assign prow   = tvalid_reg[t_reg] ? prd_reg : '0;

    always_comb begin
        cwrow = tvalid_reg[lt_reg] ? crd_reg : '0;
        pwrow = tvalid_reg[lt_reg] ? prd_reg : '0;
        cwrow[lp_reg] = lc_reg;
        pwrow[lp_reg] = lpr_reg;
    end

    assign pready   = 1'b1;
    assign prdata   = {25'd0, count_reg};
    assign s_ready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_valid  = ovalid_reg;
    assign m_distance    = odist_reg;
    assign m_order_place = oord_reg;
    assign m_done_res    = 1'b1;

    always_comb begin
        state_next = state_reg;
        dwe = 1'b0; dwaddr = {i_reg, j_reg}; dwdata = '0;
        owe = 1'b0; owaddr = {i_reg, k_reg};
        draddr = {i_reg, k_reg};
        oraddr = {qa_reg, qb_reg};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (s_cmd)
                        CMD_CLEAR:   state_next = ST_OUT;
                        CMD_LOAD:    state_next = ST_LWR;
                        CMD_COMPUTE: state_next = ST_INIT;
                        CMD_QUERY:   state_next = ST_QRD;
                    endcase
                end
            end
            ST_LWR: state_next = ST_OUT;
            ST_INIT: begin
                dwe = 1'b1;
                dwdata = (i_reg == j_reg) ? '0 : INF_CODE;
                if (last_i && last_j) begin
                    state_next = ST_SEEDT;
                end
            end
            ST_SEEDT: state_next = ST_SEEDW;
            ST_SEEDW: begin
                dwe = crow[i_reg] && prow[j_reg] && (i_reg != j_reg);
                dwdata = DistW'(1);
                if (last_i && last_j) begin
                    state_next = (t_reg == TransW'(MaxTransitions - 1)) ? ST_FWA : ST_SEEDT;
                end
            end
            ST_FWA: begin
                draddr = {i_reg, k_reg};
                state_next = ST_FWB;
            end
            ST_FWB: begin
                draddr = {k_reg, j_reg};
                state_next = ST_FWC;
            end
            ST_FWC: begin
                draddr = {i_reg, j_reg};
                state_next = ST_FWD;
            end
            ST_FWD: begin
                dwe = sat < drdata;
                dwdata = sat;
                if (last_i && last_j && last_k) begin
                    state_next = ST_SRD;
                end else begin
                    state_next = ST_FWA;
                end
            end
            ST_SRD: begin
                draddr = {j_reg, i_reg};
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                state_next = last_j ? ST_SWR : ST_SRD;
            end
            ST_SWR: begin
                owe = 1'b1;
                state_next = (last_i && last_k) ? ST_OUT : ST_SRD;
            end
            ST_QRD: begin
                draddr = {qa_reg, qb_reg};
                state_next = ST_QOUT;
            end
            ST_QOUT: state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    pdm_dist_ram u_dist (
        .aclk(aclk), .we(dwe), .waddr(dwaddr), .wdata(dwdata),
        .raddr(draddr), .rdata(drdata)
    );

    pdm_order_ram u_order (
        .aclk(aclk), .we(owe), .waddr(owaddr), .wdata(pick_reg),
        .raddr(oraddr), .rdata(ordata)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LWR) begin
            cons_mem[lt_reg] <= cwrow;
            prod_mem[lt_reg] <= pwrow;
        end
        crd_reg <= cons_mem[fraddr];
        prd_reg <= prod_mem[fraddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= CountW'(MaxPlaces);
            ovalid_reg <= 1'b0;
            tvalid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr == 2'd0) begin
                count_reg <= pwdata[CountW-1:0];
            end
            if (ovalid_reg && m_ready) begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT) begin
                ovalid_reg <= 1'b1;
            end
            if (state_reg == ST_IDLE && s_valid && s_ready && s_cmd == CMD_CLEAR) begin
                tvalid_reg <= '0;
            end
            if (state_reg == ST_LWR) begin
                tvalid_reg[lt_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                i_reg <= '0; j_reg <= '0; k_reg <= '0; t_reg <= '0;
                qa_reg <= s_place_a; qb_reg <= s_place_b;
                qin_reg <= ({1'b0, s_place_a} < n_eff) && ({1'b0, s_place_b} < n_eff);
                lt_reg <= s_transition_index;
                lp_reg <= s_place_a;
                lc_reg <= wdiff > 0;
                lpr_reg <= wdiff < 0;
                if (s_valid && s_ready) begin
                    odist_reg <= '0; oord_reg <= '0;
                end
            end
            ST_LWR: ;
            ST_INIT: begin
                j_reg <= last_j ? '0 : j_reg + 1'b1;
                if (last_j) begin
                    i_reg <= last_i ? '0 : i_reg + 1'b1;
                end
            end
            ST_SEEDT: ;
            ST_SEEDW: begin
                j_reg <= last_j ? '0 : j_reg + 1'b1;
                if (last_j) begin
                    i_reg <= last_i ? '0 : i_reg + 1'b1;
                    if (last_i) begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
            end
            ST_FWA: ;
            ST_FWB: a_reg <= drdata;
            ST_FWC: b_reg <= drdata;
            ST_FWD: begin
                j_reg <= last_j ? '0 : j_reg + 1'b1;
                if (last_j) begin
                    i_reg <= last_i ? '0 : i_reg + 1'b1;
                    if (last_i) begin
                        k_reg <= last_k ? '0 : k_reg + 1'b1;
                    end
                end
                taken_reg <= '0;
                best_reg  <= INF_CODE;
                pick_reg  <= '0;
            end
            ST_SRD: ;
            ST_SCMP: begin
                if (!taken_reg[j_reg] && drdata <= best_reg) begin
                    best_reg <= drdata;
                    pick_reg <= j_reg;
                end
                j_reg <= last_j ? '0 : j_reg + 1'b1;
            end
            ST_SWR: begin
                best_reg <= INF_CODE;
                pick_reg <= '0;
                k_reg <= last_k ? '0 : k_reg + 1'b1;
                if (last_k) begin
                    i_reg <= last_i ? '0 : i_reg + 1'b1;
                    taken_reg <= '0;
                end else begin
                    taken_reg[pick_reg] <= 1'b1;
                end
            end
            ST_QRD: ;
            ST_QOUT: begin
                odist_reg <= qin_reg ? drdata : INF_CODE;
                oord_reg  <= qin_reg ? ordata : '0;
            end
            ST_OUT: ;
            default: ;
        endcase
    end

endmodule
